// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types for the JSON string unescaper
// Result codes, the command that travels from the front end to the back end,
// and the default depth of the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // Kind of one result beat.
  typedef enum logic [1:0] {
    OUT_DATA   = 2'd0,
    OUT_CLOSED = 2'd1,
    OUT_BAD    = 2'd2
  } outcome_t;

  // One decoded input byte's worth of output: 1 to 3 bytes of one kind.
  typedef struct packed {
    logic [1:0]      nbytes;   // number of result beats, 1..3
    outcome_t        outcome;
    logic [2:0][7:0] bytes;    // bytes[0] goes out first
  } cmd_t;

  localparam int QDEPTH_DEF = 4;

endpackage : jsu_pkg

`default_nettype wire

// File: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front: escape classifier
// Tracks the escape state, gathers hex digits and turns each accepted text
// byte into at most one command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    text_byte,
  input  wire logic          at_end,
  output jsu_pkg::cmd_t      cmd,
  output logic               push
);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX0   = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_HEX2   = 3'd4,
    MODE_HEX3   = 3'd5
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;

  // Returns {valid, nibble}.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  // Returns {valid, byte}.
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic jsu_pkg::cmd_t single(input jsu_pkg::outcome_t oc, input logic [7:0] b);
    jsu_pkg::cmd_t c;
    c.nbytes  = 2'd1;
    c.outcome = oc;
    c.bytes   = {8'h00, 8'h00, b};
    return c;
  endfunction

  function automatic jsu_pkg::cmd_t utf8(input logic [15:0] cp);
    jsu_pkg::cmd_t c;
    c.outcome = jsu_pkg::OUT_DATA;
    if (cp[15:7] == 9'd0) begin
      c.nbytes = 2'd1;
      c.bytes  = {8'h00, 8'h00, 1'b0, cp[6:0]};
    end else if (cp[15:11] == 5'd0) begin
      c.nbytes = 2'd2;
      c.bytes  = {8'h00, 2'b10, cp[5:0], 3'b110, cp[10:6]};
    end else begin
      c.nbytes = 2'd3;
      c.bytes  = {2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
    end
    return c;
  endfunction

  mode_t       mode_r, mode_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic [4:0]  hexv;
  logic [8:0]  escv;
  logic [15:0] cp_shift;

  assign hexv     = hex_value(text_byte);
  assign escv     = simple_escape(text_byte);
  assign cp_shift = {cp_r[11:0], hexv[3:0]};

  always_comb begin
    mode_nxt = mode_r;
    cp_nxt   = cp_r;
    push     = 1'b0;
    cmd      = single(jsu_pkg::OUT_BAD, 8'h00);
    if (accept) begin
      if (at_end) begin
        push     = 1'b1;
        mode_nxt = MODE_NORMAL;
      end else begin
        case (mode_r)
          MODE_ESCAPE: begin
            mode_nxt = MODE_NORMAL;
            if (escv[8]) begin
              push = 1'b1;
              cmd  = single(jsu_pkg::OUT_DATA, escv[7:0]);
            end else if (text_byte == CH_U) begin
              mode_nxt = MODE_HEX0;
              cp_nxt   = 16'd0;
            end else begin
              push = 1'b1;
            end
          end
          MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
            if (!hexv[4]) begin
              push     = 1'b1;
              mode_nxt = MODE_NORMAL;
            end else begin
              cp_nxt   = cp_shift;
              mode_nxt = mode_t'(mode_r + 3'd1);
            end
          end
          MODE_HEX3: begin
            push     = 1'b1;
            mode_nxt = MODE_NORMAL;
            if (hexv[4]) begin
              cp_nxt = cp_shift;
              cmd    = utf8(cp_shift);
            end
          end
          default: begin
            mode_nxt = MODE_NORMAL;
            if (text_byte == CH_QUOTE) begin
              push = 1'b1;
              cmd  = single(jsu_pkg::OUT_CLOSED, 8'h00);
            end else if (text_byte == CH_BSL) begin
              mode_nxt = MODE_ESCAPE;
            end else begin
              push = 1'b1;
              cmd  = single(jsu_pkg::OUT_DATA, text_byte);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      cp_r   <= 16'd0;
    end else begin
      mode_r <= mode_nxt;
      cp_r   <= cp_nxt;
    end
  end

endmodule : jsu_front

`default_nettype wire

// File: rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue: command queue
// Small FIFO of commands between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QDEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire jsu_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output jsu_pkg::cmd_t      head_cmd,
  output logic               full,
  output logic               empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule : jsu_queue

`default_nettype wire

// File: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back: output sequencer
// Walks the bytes of the head command and drives the registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire jsu_pkg::cmd_t head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic [1:0]         out_code,
  output logic               out_last
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic [1:0] code_r;
  logic       last_r;
  logic       load, last_now;

  assign load     = !q_empty && (!valid_r || out_ready);
  assign last_now = (idx_r == head_cmd.nbytes - 2'd1);
  assign pop      = load && last_now;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = last_now ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
    if (load) begin
      byte_r <= head_cmd.bytes[idx_r];
      code_r <= head_cmd.outcome;
      last_r <= last_now;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_code  = code_r;
  assign out_last  = last_r;

endmodule : jsu_back

`default_nettype wire

// File: rtl/json_string_unescape_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_top: JSON string body unescaper
// Decodes the bytes after the opening quote of a JSON string into raw bytes,
// expanding simple escapes and \u escapes (as UTF-8), and flags the closing
// quote or malformed text.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one text byte per beat in in_tdata; in_tuser set
//   means the text ran out and the byte is ignored. The output stream carries
//   one decoded byte per beat in out_tdata, the kind of beat in out_tuser
//   (data, string closed, malformed) and out_tlast on the final beat caused
//   by one input beat. Backslash, 'u' and the first three hex digits of a
//   \u escape cause no output beat at all.
//   The sequencer registers the first result beat of an accepted input beat
//   from the command queue. Throughput is one input beat per cycle unless the
//   queue is full; the output side moves one beat per cycle while out_tready
//   is high, so a \u escape of two or three UTF-8 bytes holds the sequencer
//   for one beat per byte, and the command queue (DEPTH entries) absorbs the
//   burst so that input keeps flowing. in_tready drops only when the queue is
//   full, when the receiver stalls out_tready or long escapes outpace it.
//   Results are held stable while out_tready is low. Synchronous reset empties
//   the queue, drops any pending beat and returns the decoder to normal mode.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_top #(
  parameter int DEPTH = jsu_pkg::QDEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  input  wire logic       in_tuser,   // [0] at_end
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [1:0]      out_tuser,  // [1:0] outcome
  output logic            out_tlast   // last_of_run
);

  jsu_pkg::cmd_t push_cmd, head_cmd;
  logic          push, pop, q_full, q_empty, accept;

  // The classifier never stalls on its own; only a full queue holds input.
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .text_byte (in_tdata),
    .at_end    (in_tuser),
    .cmd       (push_cmd),
    .push      (push)
  );

  jsu_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // The sequencer emits one byte of the head command per beat and releases
  // the command with its last byte.
  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_code  (out_tuser),
    .out_last  (out_tlast)
  );

endmodule : json_string_unescape_top

`default_nettype wire

// File: tb/sv/json_string_unescape_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_unescape_checker: scoreboard for the JSON string unescaper
// Watches both streams of the unescaper. Every accepted input beat runs
// through a decoder model that keeps its own escape state and queues the
// bytes it decodes. Each accepted output beat is compared with the oldest
// queued byte, one field at a time.
// ----------------------------------------------------------------------------

package jsu_text_pkg;

  // Characters with a meaning inside a JSON string body.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_F   = 8'h46;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LETTER_B  = 8'h62;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LETTER_N  = 8'h6E;
  localparam logic [7:0] CH_LETTER_R  = 8'h72;
  localparam logic [7:0] CH_LETTER_T  = 8'h74;
  localparam logic [7:0] CH_LETTER_U  = 8'h75;

  // Control bytes that the simple escapes stand for.
  localparam logic [7:0] ASCII_BS  = 8'h08;
  localparam logic [7:0] ASCII_TAB = 8'h09;
  localparam logic [7:0] ASCII_LF  = 8'h0A;
  localparam logic [7:0] ASCII_FF  = 8'h0C;
  localparam logic [7:0] ASCII_CR  = 8'h0D;

  // Bit 8 is set when the letter after a backslash is one of the simple
  // escapes; the low byte is then the byte it stands for.
  function automatic logic [8:0] escape_byte(input logic [7:0] letter);
    case (letter)
      CH_QUOTE, CH_BACKSLASH, CH_SLASH: escape_byte = {1'b1, letter};
      CH_LETTER_B: escape_byte = {1'b1, ASCII_BS};
      CH_LOWER_F:  escape_byte = {1'b1, ASCII_FF};
      CH_LETTER_N: escape_byte = {1'b1, ASCII_LF};
      CH_LETTER_R: escape_byte = {1'b1, ASCII_CR};
      CH_LETTER_T: escape_byte = {1'b1, ASCII_TAB};
      default:     escape_byte = 9'h000;
    endcase
  endfunction

  // Bit 4 is set for a hex digit of either case; the low nibble is its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    logic [7:0] offset;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      offset = ch - CH_ZERO;
    end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
      offset = ch - CH_UPPER_A + 8'd10;
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
      offset = ch - CH_LOWER_A + 8'd10;
    end else begin
      return 5'h00;
    end
    hex_nibble = {1'b1, offset[3:0]};
  endfunction

endpackage : jsu_text_pkg

module json_string_unescape_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic [1:0] out_tuser,
  input  logic       out_tlast,
  output int         mismatch_count,
  output int         results_pending
);
  import jsu_text_pkg::*;

  typedef enum logic [2:0] {
    SCAN_PLAIN  = 3'd0,
    SCAN_ESCAPE = 3'd1,
    SCAN_HEX0   = 3'd2,
    SCAN_HEX1   = 3'd3,
    SCAN_HEX2   = 3'd4,
    SCAN_HEX3   = 3'd5
  } scan_mode_t;

  typedef struct {
    logic [7:0]         data;
    jsu_pkg::outcome_t  kind;
    logic               last;
  } decoded_beat_t;

  decoded_beat_t decoded_q[$];
  scan_mode_t    scan_mode = SCAN_PLAIN;
  logic [15:0]   code_point = '0;
  int            results_seen = 0;

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("%0t ns: result beat %0d: %s", $time, results_seen, msg);
    end
  endtask

  task automatic queue_byte(input logic [7:0] data, input jsu_pkg::outcome_t kind,
                            input logic last);
    decoded_beat_t beat;
    beat.data = data;
    beat.kind = kind;
    beat.last = last;
    decoded_q.push_back(beat);
  endtask

  task automatic decode_text_byte(input logic [7:0] ch, input logic at_end);
    logic [8:0] esc;
    logic [4:0] nib;
    esc = escape_byte(ch);
    nib = hex_nibble(ch);
    if (at_end) begin
      scan_mode = SCAN_PLAIN;
      queue_byte(8'h00, jsu_pkg::OUT_BAD, 1'b1);
    end else begin
      case (scan_mode)
        SCAN_ESCAPE: begin
          scan_mode = SCAN_PLAIN;
          if (esc[8]) begin
            queue_byte(esc[7:0], jsu_pkg::OUT_DATA, 1'b1);
          end else if (ch == CH_LETTER_U) begin
            scan_mode  = SCAN_HEX0;
            code_point = '0;
          end else begin
            queue_byte(8'h00, jsu_pkg::OUT_BAD, 1'b1);
          end
        end
        SCAN_HEX0, SCAN_HEX1, SCAN_HEX2, SCAN_HEX3: begin
          if (!nib[4]) begin
            scan_mode = SCAN_PLAIN;
            queue_byte(8'h00, jsu_pkg::OUT_BAD, 1'b1);
          end else begin
            code_point = {code_point[11:0], nib[3:0]};
            if (scan_mode != SCAN_HEX3) begin
              scan_mode = scan_mode_t'(scan_mode + 3'd1);
            end else begin
              // Fourth digit: emit the code point as UTF-8, no surrogate pairing.
              scan_mode = SCAN_PLAIN;
              if (code_point < 16'h0080) begin
                queue_byte(code_point[7:0], jsu_pkg::OUT_DATA, 1'b1);
              end else if (code_point < 16'h0800) begin
                queue_byte(8'hC0 | code_point[10:6], jsu_pkg::OUT_DATA, 1'b0);
                queue_byte(8'h80 | code_point[5:0], jsu_pkg::OUT_DATA, 1'b1);
              end else begin
                queue_byte(8'hE0 | code_point[15:12], jsu_pkg::OUT_DATA, 1'b0);
                queue_byte(8'h80 | code_point[11:6], jsu_pkg::OUT_DATA, 1'b0);
                queue_byte(8'h80 | code_point[5:0], jsu_pkg::OUT_DATA, 1'b1);
              end
            end
          end
        end
        default: begin
          scan_mode = SCAN_PLAIN;
          if (ch == CH_QUOTE) begin
            queue_byte(8'h00, jsu_pkg::OUT_CLOSED, 1'b1);
          end else if (ch == CH_BACKSLASH) begin
            scan_mode = SCAN_ESCAPE;
          end else begin
            queue_byte(ch, jsu_pkg::OUT_DATA, 1'b1);
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    decoded_beat_t want;
    if (!rst_n) begin
      scan_mode  = SCAN_PLAIN;
      code_point = '0;
      decoded_q.delete();
    end else begin
      // Output first: a result can never belong to an input taken at the same edge.
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat data=%02h kind=%0d last=%0b",
                                    out_tdata, out_tuser, out_tlast));
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata !== want.data) begin
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_tdata, want.data));
          end
          if (out_tuser !== want.kind) begin
            report_mismatch($sformatf("outcome %0d, expected %0d", out_tuser, want.kind));
          end
          if (out_tlast !== want.last) begin
            report_mismatch($sformatf("last_of_run %0b, expected %0b", out_tlast, want.last));
          end
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        decode_text_byte(in_tdata, in_tuser);
      end
    end
    results_pending = decoded_q.size();
  end

endmodule : json_string_unescape_checker

// File: tb/sv/tb_json_string_unescape_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_top: stimulus and verdict for the string unescaper
// Feeds string body text to the unescaper: a directed set of corner cases,
// then randomly built strings made mostly of well-formed escapes with some
// broken ones mixed in, under several idle and stall patterns. A separate
// checker module predicts and compares every result beat.
// ----------------------------------------------------------------------------

module tb_json_string_unescape_top;
  import jsu_text_pkg::*;

  // Random beats per idle phase; four phases plus the directed part give
  // roughly 350 input beats in all.
  localparam int PHASE_BEATS = 80;
  // Length of the forced output hold-off, long enough to fill the result queue.
  localparam int LONG_HOLD   = 80;
  // Cycles without any beat on either side before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Quiet cycles after the last result before the final verdict.
  localparam int TAIL_CYCLES = 10;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] text_byte
  logic       in_tuser   = 1'b0;   // [0] at_end
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_byte
  logic [1:0] out_tuser;           // [1:0] outcome
  logic       out_tlast;

  int   mismatch_count;
  int   results_pending;
  int   beats_sent    = 0;
  int   in_idle_pct   = 0;
  int   out_stall_pct = 0;
  int   quiet_cycles  = 0;

  // The stimulus flips hold_toggle to ask the receiver for one long hold-off;
  // the receiver counts the stretch down in its own process.
  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;

  json_string_unescape_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  json_string_unescape_checker checker_inst (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: random back-pressure at out_stall_pct, or a long forced hold-off
  // when the stimulus asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen  <= hold_toggle;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Watchdog: any beat on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one text beat and returns at the edge where it is taken. An idle gap
  // comes first with probability in_idle_pct; tvalid is only lowered when such
  // a gap follows, so back-to-back beats keep it high.
  task automatic send_beat(input logic [7:0] text_byte, input logic at_end);
    if ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= text_byte;
    in_tuser  <= at_end;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // Stops offering and waits until the checker holds no expected result.
  // The pending count is sampled at the falling edge, well clear of updates.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    @(posedge clk);
  endtask

  // Backslash followed by one of the eight simple escape letters.
  task automatic send_simple_escape(input int which);
    logic [7:0] letter;
    case (which)
      0:       letter = CH_QUOTE;
      1:       letter = CH_BACKSLASH;
      2:       letter = CH_SLASH;
      3:       letter = CH_LETTER_B;
      4:       letter = CH_LOWER_F;
      5:       letter = CH_LETTER_N;
      6:       letter = CH_LETTER_R;
      default: letter = CH_LETTER_T;
    endcase
    send_beat(CH_BACKSLASH, 1'b0);
    send_beat(letter, 1'b0);
  endtask

  // Backslash, u and the first n_digits hex digits of code_pt, each digit in a
  // random case. Four digits make a complete escape.
  task automatic send_hex_prefix(input logic [15:0] code_pt, input int n_digits);
    logic [3:0] nib;
    logic [7:0] ch;
    send_beat(CH_BACKSLASH, 1'b0);
    send_beat(CH_LETTER_U, 1'b0);
    for (int i = 0; i < n_digits; i++) begin
      nib = code_pt[(3 - i) * 4 +: 4];
      if (nib < 4'd10) begin
        ch = CH_ZERO + nib;
      end else begin
        ch = ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + nib - 8'd10;
      end
      send_beat(ch, 1'b0);
    end
  endtask

  // One random piece of string text. Most pieces are well formed; a minority
  // are broken escapes, early ends of text or raw noise bytes.
  task automatic send_random_piece();
    int         pick;
    int         depth;
    logic [7:0] ch;
    logic [8:0] esc;
    logic [4:0] nib;
    logic [15:0] code_pt;
    pick = $urandom_range(99);
    if (pick < 35) begin
      // Plain byte that passes straight through.
      do ch = 8'($urandom); while (ch == CH_QUOTE || ch == CH_BACKSLASH);
      send_beat(ch, 1'b0);
    end else if (pick < 50) begin
      send_simple_escape($urandom_range(7));
    end else if (pick < 72) begin
      // Full \u escape; the code point range decides the UTF-8 length.
      case ($urandom_range(3))
        0:       code_pt = 16'($urandom_range(16'h007F));
        1:       code_pt = 16'($urandom_range(16'h07FF, 16'h0080));
        2:       code_pt = 16'($urandom_range(16'hFFFF, 16'h0800));
        default: code_pt = 16'($urandom);
      endcase
      send_hex_prefix(code_pt, 4);
    end else if (pick < 78) begin
      send_beat(CH_QUOTE, 1'b0);
    end else if (pick < 82) begin
      // Unknown letter after a backslash.
      do begin
        ch  = 8'($urandom);
        esc = escape_byte(ch);
      end while (esc[8] || ch == CH_LETTER_U);
      send_beat(CH_BACKSLASH, 1'b0);
      send_beat(ch, 1'b0);
    end else if (pick < 87) begin
      // A non-hex byte in place of any of the four digits.
      do begin
        ch  = 8'($urandom);
        nib = hex_nibble(ch);
      end while (nib[4]);
      send_hex_prefix(16'($urandom), $urandom_range(3));
      send_beat(ch, 1'b0);
    end else if (pick < 93) begin
      // Text runs out in plain text, after a backslash or part way into \u.
      depth = $urandom_range(5);
      if (depth == 1) begin
        send_beat(CH_BACKSLASH, 1'b0);
      end else if (depth >= 2) begin
        send_hex_prefix(16'($urandom), depth - 2);
      end
      send_beat(8'($urandom), 1'b1);
    end else begin
      send_beat(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    int phase_start;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: byte extremes, the closing quote, every simple escape,
    // \u0000 and the largest code point, then each malformed case.
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(CH_QUOTE, 1'b0);
    for (int i = 0; i < 8; i++) begin
      send_simple_escape(i);
    end
    send_hex_prefix(16'h0000, 4);
    send_hex_prefix(16'hFFFF, 4);
    send_beat(CH_BACKSLASH, 1'b0);
    send_beat("q", 1'b0);
    send_beat(CH_BACKSLASH, 1'b0);
    send_beat(CH_LETTER_U, 1'b0);
    send_beat("g", 1'b0);
    send_beat(8'hFF, 1'b1);
    wait_drained();

    // Random part, one phase per idle pattern. Every phase ends with the sender
    // paused until all expected results are in.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          // No idling, except one long receiver hold-off at the start that
          // fills the result queue and pushes back on the input.
          in_idle_pct = 0;
          out_stall_pct <= 0;
          hold_toggle <= ~hold_toggle;
        end
        1: begin
          in_idle_pct = 69;
          out_stall_pct <= 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct <= 69;
        end
        default: begin
          in_idle_pct = 32;
          out_stall_pct <= 32;
        end
      endcase
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        send_random_piece();
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule : tb_json_string_unescape_top
